// ===== hw/rtl/assert_macros.svh =====
// Assertion shorthands shared by the decoder modules.
// Both expect a clock named clk and an active-low reset named arst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge out of reset.
`define HSFD_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// Consequence that must hold in the cycle after the antecedent.
`define HSFD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/hsfd_pkg.sv =====
package hsfd_pkg;

	// Byte positions inside a reply frame
	localparam logic [2:0] POS_T_HI  = 3'd0;
	localparam logic [2:0] POS_T_LO  = 3'd1;
	localparam logic [2:0] POS_T_CRC = 3'd2;
	localparam logic [2:0] POS_H_HI  = 3'd3;
	localparam logic [2:0] POS_H_LO  = 3'd4;
	localparam logic [2:0] POS_H_CRC = 3'd5;

	localparam logic [7:0] CRC_POLY = 8'h31;
	localparam logic [7:0] CRC_INIT = 8'hFF;

	// Conversion constants
	localparam logic [30:0] TEMP_SPAN   = 31'd17500;
	localparam logic [30:0] HUM_SPAN    = 31'd10000;
	localparam logic [15:0] TEMP_OFFSET = 16'd22815;
	localparam logic [31:0] RAW_FULL    = 32'd65535;

	// Register indexes on the configuration port
	localparam logic REG_FRAME_KIND = 1'b0;

	localparam logic KIND_MEASURE = 1'b0;
	localparam logic KIND_STATUS  = 1'b1;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic       frame_start;
	} hsfd_in_t;

	typedef struct packed {
		logic [15:0] temperature_centikelvin;
		logic [13:0] humidity_centipercent;
		logic [15:0] status_word;
		logic        crc_ok;
		logic        values_updated;
	} hsfd_out_t;

	// Finished frame handed from the byte decoder to the scaling pipeline
	typedef struct packed {
		logic [15:0] status_word;
		logic [15:0] raw_humidity;
		logic        crc_ok;
		logic        values_updated;
	} hsfd_emit_t;

	function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
		logic [7:0] r;
		r = crc ^ data;
		for (int i = 0; i < 8; i++) begin
			if (r[7]) begin
				r = {r[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				r = {r[6:0], 1'b0};
			end
		end
		return r;
	endfunction

	// Quotient by 65535, low by at most one: (x + x/65536) / 65536
	function automatic logic [15:0] quot_est(input logic [30:0] x);
		logic [31:0] s;
		s = {1'b0, x} + {17'd0, x[30:16]};
		return s[31:16];
	endfunction

	// Bump the estimate when the remainder still reaches the divisor
	function automatic logic [15:0] quot_fix(input logic [30:0] x, input logic [15:0] q);
		logic [31:0] r;
		r = {1'b0, x} + {16'd0, q} - {q, 16'd0};
		return (r >= RAW_FULL) ? q + 16'd1 : q;
	endfunction

endpackage

// ===== hw/rtl/hsfd_frame.sv =====
`include "assert_macros.svh"

module hsfd_frame (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               adv,
	input  logic               in_valid,
	input  hsfd_pkg::hsfd_in_t in_data,
	input  logic               frame_kind,
	output logic               valid_s2,
	output hsfd_pkg::hsfd_emit_t emit_s2
);

	logic               valid_s1;
	hsfd_pkg::hsfd_in_t item_s1;

	logic [2:0]  pos_q;
	logic [7:0]  crc_q;
	logic [15:0] first_word_q;
	logic [7:0]  second_hi_q;
	logic [7:0]  second_lo_q;
	logic        first_good_q;

	logic [2:0]  pos_cur;
	logic [2:0]  pos_d;
	logic [7:0]  crc_d;
	logic [15:0] first_word_d;
	logic [7:0]  second_hi_d;
	logic [7:0]  second_lo_d;
	logic        first_good_d;
	logic        emit;
	hsfd_pkg::hsfd_emit_t emit_d;
	logic        crc_match;
	logic [7:0]  crc_step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			item_s1 <= in_data;
		end
	end

	always_comb begin
		pos_cur = (item_s1.frame_start || pos_q > hsfd_pkg::POS_H_CRC) ?
			hsfd_pkg::POS_T_HI : pos_q;
		crc_match = (crc_q == item_s1.rx_byte);
		crc_step = hsfd_pkg::crc8_byte(
			(pos_cur == hsfd_pkg::POS_T_HI || pos_cur == hsfd_pkg::POS_H_HI) ?
			hsfd_pkg::CRC_INIT : crc_q, item_s1.rx_byte);
		pos_d        = pos_cur;
		crc_d        = crc_q;
		first_word_d = first_word_q;
		second_hi_d  = second_hi_q;
		second_lo_d  = second_lo_q;
		first_good_d = first_good_q;
		emit         = 1'b0;
		emit_d.status_word    = first_word_q;
		emit_d.raw_humidity   = {second_hi_q, second_lo_q};
		emit_d.crc_ok         = 1'b0;
		emit_d.values_updated = 1'b0;
		case (pos_cur)
			hsfd_pkg::POS_T_HI: begin
				crc_d = crc_step;
				first_word_d[15:8] = item_s1.rx_byte;
				pos_d = hsfd_pkg::POS_T_LO;
			end
			hsfd_pkg::POS_T_LO: begin
				crc_d = crc_step;
				first_word_d[7:0] = item_s1.rx_byte;
				pos_d = hsfd_pkg::POS_T_CRC;
			end
			hsfd_pkg::POS_T_CRC: begin
				first_good_d = crc_match;
				crc_d = hsfd_pkg::CRC_INIT;
				if (frame_kind == hsfd_pkg::KIND_STATUS) begin
					pos_d = hsfd_pkg::POS_T_HI;
					emit = 1'b1;
					emit_d.crc_ok = crc_match;
				end else begin
					pos_d = hsfd_pkg::POS_H_HI;
				end
			end
			hsfd_pkg::POS_H_HI: begin
				crc_d = crc_step;
				second_hi_d = item_s1.rx_byte;
				pos_d = hsfd_pkg::POS_H_LO;
			end
			hsfd_pkg::POS_H_LO: begin
				crc_d = crc_step;
				second_lo_d = item_s1.rx_byte;
				pos_d = hsfd_pkg::POS_H_CRC;
			end
			default: begin
				crc_d = hsfd_pkg::CRC_INIT;
				pos_d = hsfd_pkg::POS_T_HI;
				emit = 1'b1;
				emit_d.crc_ok = first_good_q && crc_match;
				emit_d.values_updated = first_good_q && crc_match;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q        <= hsfd_pkg::POS_T_HI;
			crc_q        <= hsfd_pkg::CRC_INIT;
			first_word_q <= '0;
			second_hi_q  <= '0;
			second_lo_q  <= '0;
			first_good_q <= 1'b0;
			valid_s2     <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1 && emit;
			if (valid_s1) begin
				pos_q        <= pos_d;
				crc_q        <= crc_d;
				first_word_q <= first_word_d;
				second_hi_q  <= second_hi_d;
				second_lo_q  <= second_lo_d;
				first_good_q <= first_good_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			emit_s2 <= emit_d;
		end
	end

	`HSFD_ASSERT(pos_in_range, pos_q <= hsfd_pkg::POS_H_CRC, "byte position out of range")
	`HSFD_ASSERT_NEXT(emit_rewinds, adv && valid_s1 && emit, pos_q == hsfd_pkg::POS_T_HI, "position not rewound after frame end")
	`HSFD_ASSERT_NEXT(emit_at_ends, adv && valid_s1 && pos_cur != hsfd_pkg::POS_T_CRC && pos_cur != hsfd_pkg::POS_H_CRC, !valid_s2, "result emitted on a data byte")

endmodule

// ===== hw/rtl/hsfd_scale.sv =====
`include "assert_macros.svh"

module hsfd_scale (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 adv,
	input  logic                 valid_s2,
	input  hsfd_pkg::hsfd_emit_t emit_s2,
	output logic                 out_valid,
	output hsfd_pkg::hsfd_out_t  out_data
);

	logic        valid_s3;
	logic        valid_s4;
	hsfd_pkg::hsfd_emit_t emit_s3;
	hsfd_pkg::hsfd_emit_t emit_s4;
	logic [30:0] prod_t_s3;
	logic [30:0] prod_h_s3;
	logic [30:0] prod_t_s4;
	logic [30:0] prod_h_s4;
	logic [15:0] qe_t_s4;
	logic [15:0] qe_h_s4;

	logic [15:0] held_t_q;
	logic [13:0] held_h_q;

	logic [15:0] quot_t;
	logic [15:0] quot_h;
	logic [15:0] temp_d;
	logic [13:0] hum_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3  <= 1'b0;
			valid_s4  <= 1'b0;
			out_valid <= 1'b0;
		end else if (adv) begin
			valid_s3  <= valid_s2;
			valid_s4  <= valid_s3;
			out_valid <= valid_s4;
		end
	end

	// Multiply, then estimate the quotient by 65535
	always_ff @(posedge clk) begin
		if (adv) begin
			emit_s3   <= emit_s2;
			prod_t_s3 <= {15'd0, emit_s2.status_word} * hsfd_pkg::TEMP_SPAN;
			prod_h_s3 <= {15'd0, emit_s2.raw_humidity} * hsfd_pkg::HUM_SPAN;
			emit_s4   <= emit_s3;
			prod_t_s4 <= prod_t_s3;
			prod_h_s4 <= prod_h_s3;
			qe_t_s4   <= hsfd_pkg::quot_est(prod_t_s3);
			qe_h_s4   <= hsfd_pkg::quot_est(prod_h_s3);
		end
	end

	always_comb begin
		quot_t = hsfd_pkg::quot_fix(prod_t_s4, qe_t_s4);
		quot_h = hsfd_pkg::quot_fix(prod_h_s4, qe_h_s4);
		if (valid_s4 && emit_s4.values_updated) begin
			temp_d = quot_t + hsfd_pkg::TEMP_OFFSET;
			hum_d  = quot_h[13:0];
		end else begin
			temp_d = held_t_q;
			hum_d  = held_h_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_t_q <= '0;
			held_h_q <= '0;
		end else if (adv) begin
			held_t_q <= temp_d;
			held_h_q <= hum_d;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_data.temperature_centikelvin <= temp_d;
			out_data.humidity_centipercent   <= hum_d;
			out_data.status_word             <= emit_s4.status_word;
			out_data.crc_ok                  <= emit_s4.crc_ok;
			out_data.values_updated          <= emit_s4.values_updated;
		end
	end

	`HSFD_ASSERT(upd_needs_crc, !(out_valid && out_data.values_updated && !out_data.crc_ok), "update without good CRC")
	`HSFD_ASSERT(temp_range, held_t_q == 16'd0 || (held_t_q >= hsfd_pkg::TEMP_OFFSET && held_t_q <= 16'd40315), "held temperature out of range")
	`HSFD_ASSERT(hum_range, held_h_q <= 14'd10000, "held humidity out of range")

endmodule

// ===== hw/rtl/humidity_sensor_frame_decoder_unit.sv =====
// After its last byte, a result passes the decode, multiply and quotient registers to out_data.
// Throughput: one byte per cycle; the pipeline only holds while a result waits under out_stall.
// Stages: input register, byte decode with CRC, multiply, quotient estimate, result register.
// Reset (arst_n low, async): frame position 0, CRC 0xFF, held values 0, frame_kind 0.
// No result is pending after reset; the first byte may be taken on the first edge.
module humidity_sensor_frame_decoder_unit (
	input  logic                clk,
	input  logic                arst_n,
	// byte input channel
	input  logic                in_valid,
	output logic                in_stall,
	input  hsfd_pkg::hsfd_in_t  in_data,
	// result channel
	output logic                out_valid,
	input  logic                out_stall,
	output hsfd_pkg::hsfd_out_t out_data,
	// configuration port
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);

	logic                 adv;
	logic                 frame_kind_q;
	logic                 valid_s2;
	hsfd_pkg::hsfd_emit_t emit_s2;

	// Advance every stage together unless a finished result is held by the sink.
	assign adv      = !out_valid || !out_stall;
	assign in_stall = !adv;

	// Configuration: single frame_kind bit at byte addresses zero to three (paddr[2] low); no wait states.
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_kind_q <= hsfd_pkg::KIND_MEASURE;
		end else if (psel && penable && pwrite && paddr[2] == hsfd_pkg::REG_FRAME_KIND) begin
			frame_kind_q <= pwdata[0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == hsfd_pkg::REG_FRAME_KIND) begin
			prdata[0] = frame_kind_q;
		end
	end

	// Decode bytes, run the per-word CRC and pick out finished frames.
	hsfd_frame u_frame (
		.clk        (clk),
		.arst_n     (arst_n),
		.adv        (adv),
		.in_valid   (in_valid),
		.in_data    (in_data),
		.frame_kind (frame_kind_q),
		.valid_s2   (valid_s2),
		.emit_s2    (emit_s2)
	);

	// Scale raw words, hold the last good values, drive the result register.
	hsfd_scale u_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.valid_s2  (valid_s2),
		.emit_s2   (emit_s2),
		.out_valid (out_valid),
		.out_data  (out_data)
	);

endmodule

// ===== dv/hsfd_frame_checker.sv =====
module hsfd_frame_checker
	import hsfd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  hsfd_in_t    in_data,
	input  logic        out_valid,
	input  logic        out_stall,
	input  hsfd_out_t   out_data,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic        pready,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output int unsigned mismatch_count,
	output int unsigned readings_pending
);

	localparam logic [2:0]  FRAME_KIND_ADDR = {REG_FRAME_KIND, 2'b00};
	localparam logic [31:0] FULL_SCALE      = 32'd65535;
	localparam logic [31:0] TEMP_RANGE_CK   = 32'd17500;
	localparam logic [31:0] TEMP_ZERO_CK    = 32'd22815;
	localparam logic [31:0] HUM_RANGE_CP    = 32'd10000;

	// decoder state as the block should hold it
	logic [2:0]  frame_pos;
	logic [7:0]  word_crc;
	logic [15:0] raw_temp;
	logic [7:0]  raw_hum_hi;
	logic [7:0]  raw_hum_lo;
	logic        temp_crc_good;
	logic [15:0] held_temp_ck;
	logic [13:0] held_hum_cp;
	logic        kind;

	hsfd_out_t   expected_readings[$];
	int unsigned fail_tally;

	function automatic logic [7:0] crc_next(input logic [7:0] c, input logic [7:0] d);
		logic fb;
		for (int i = 7; i >= 0; i--) begin
			fb = c[7] ^ d[i];
			c = {c[6:0], 1'b0};
			if (fb) begin
				c = c ^ CRC_POLY;
			end
		end
		return c;
	endfunction

	task automatic decode_byte(input hsfd_in_t it);
		logic [2:0]  p;
		logic [7:0]  b;
		logic        ok;
		logic [31:0] scaled;
		hsfd_out_t   r;
		b = it.rx_byte;
		p = it.frame_start ? POS_T_HI : frame_pos;
		if (p > POS_H_CRC) begin
			p = POS_T_HI;
		end
		case (p)
			POS_T_HI: begin
				word_crc = crc_next(CRC_INIT, b);
				raw_temp[15:8] = b;
				frame_pos = POS_T_LO;
			end
			POS_T_LO: begin
				word_crc = crc_next(word_crc, b);
				raw_temp[7:0] = b;
				frame_pos = POS_T_CRC;
			end
			POS_T_CRC: begin
				temp_crc_good = (word_crc == b);
				word_crc = CRC_INIT;
				// kind is looked at here only; later bytes keep measurement decoding
				if (kind == KIND_STATUS) begin
					frame_pos = POS_T_HI;
					r.temperature_centikelvin = held_temp_ck;
					r.humidity_centipercent   = held_hum_cp;
					r.status_word             = raw_temp;
					r.crc_ok                  = temp_crc_good;
					r.values_updated          = 1'b0;
					expected_readings.push_back(r);
				end else begin
					frame_pos = POS_H_HI;
				end
			end
			POS_H_HI: begin
				word_crc = crc_next(CRC_INIT, b);
				raw_hum_hi = b;
				frame_pos = POS_H_LO;
			end
			POS_H_LO: begin
				word_crc = crc_next(word_crc, b);
				raw_hum_lo = b;
				frame_pos = POS_H_CRC;
			end
			default: begin
				ok = temp_crc_good && (word_crc == b);
				if (ok) begin
					scaled = {16'd0, raw_temp} * TEMP_RANGE_CK;
					held_temp_ck = 16'(scaled / FULL_SCALE + TEMP_ZERO_CK);
					scaled = {16'd0, raw_hum_hi, raw_hum_lo} * HUM_RANGE_CP;
					held_hum_cp = 14'(scaled / FULL_SCALE);
				end
				word_crc = CRC_INIT;
				frame_pos = POS_T_HI;
				r.temperature_centikelvin = held_temp_ck;
				r.humidity_centipercent   = held_hum_cp;
				r.status_word             = raw_temp;
				r.crc_ok                  = ok;
				r.values_updated          = ok;
				expected_readings.push_back(r);
			end
		endcase
	endtask

	task automatic check_reading(input hsfd_out_t got);
		hsfd_out_t want;
		if (expected_readings.size() == 0) begin
			$error("result with nothing pending: status_word %h crc_ok %b", got.status_word,
				got.crc_ok);
			fail_tally++;
			return;
		end
		want = expected_readings.pop_front();
		if (got.temperature_centikelvin !== want.temperature_centikelvin) begin
			$error("temperature_centikelvin: expected %0d, actual %0d",
				want.temperature_centikelvin, got.temperature_centikelvin);
			fail_tally++;
		end
		if (got.humidity_centipercent !== want.humidity_centipercent) begin
			$error("humidity_centipercent: expected %0d, actual %0d",
				want.humidity_centipercent, got.humidity_centipercent);
			fail_tally++;
		end
		if (got.status_word !== want.status_word) begin
			$error("status_word: expected %h, actual %h", want.status_word, got.status_word);
			fail_tally++;
		end
		if (got.crc_ok !== want.crc_ok) begin
			$error("crc_ok: expected %b, actual %b", want.crc_ok, got.crc_ok);
			fail_tally++;
		end
		if (got.values_updated !== want.values_updated) begin
			$error("values_updated: expected %b, actual %b", want.values_updated,
				got.values_updated);
			fail_tally++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_pos     = POS_T_HI;
			word_crc      = CRC_INIT;
			raw_temp      = '0;
			raw_hum_hi    = '0;
			raw_hum_lo    = '0;
			temp_crc_good = 1'b0;
			held_temp_ck  = '0;
			held_hum_cp   = '0;
			kind          = KIND_MEASURE;
			expected_readings.delete();
			readings_pending <= 0;
		end else begin
			if (psel && penable && pwrite && pready && paddr == FRAME_KIND_ADDR) begin
				kind = pwdata[0];
			end
			// compare before predicting: no result leaves in the cycle its byte enters
			if (out_valid && !out_stall) begin
				check_reading(out_data);
			end
			if (in_valid && !in_stall) begin
				decode_byte(in_data);
			end
			readings_pending <= expected_readings.size();
			mismatch_count   <= fail_tally;
		end
	end

endmodule

// ===== dv/tb_top.sv =====
module tb_top;
	import hsfd_pkg::*;

	localparam logic [2:0] FRAME_KIND_ADDR = {REG_FRAME_KIND, 2'b00};
	// after the last reading is checked, idle this long before touching config
	localparam int SETTLE_CYCLES = 8;
	localparam int LONG_HOLD     = 400;
	localparam int RANDOM_BYTES  = 450;
	localparam int DRAIN_LIMIT   = 50000;
	localparam int NO_BAD_WORD   = -1;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	hsfd_in_t    in_data  = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	hsfd_out_t   out_data;
	logic        psel     = 1'b0;
	logic        penable  = 1'b0;
	logic        pwrite   = 1'b0;
	logic [2:0]  paddr    = '0;
	logic [31:0] pwdata   = '0;
	logic [31:0] prdata;
	logic        pready;
	int unsigned mismatch_count;
	int unsigned readings_pending;

	// stimulus-side bookkeeping
	bit          calm;      // no gaps on either side while set
	bit          hold_req;  // ask the receiver for one long hold-off
	bit          aligned;   // last frame ended cleanly, so a start mark is optional
	logic        kind_now = KIND_MEASURE;
	int unsigned bytes_sent;
	logic [7:0]  frame_bytes[$];

	humidity_sensor_frame_decoder_unit dut (.*);

	hsfd_frame_checker watcher (.*);

	always #6 clk = ~clk;

	// Mostly no gap, some short ones, a few long ones; nothing in a calm phase.
	function automatic int unsigned idle_len();
		int unsigned r;
		if (calm) begin
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 60) begin
			return 0;
		end
		if (r < 92) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(10, 40);
	endfunction

	// Raw words lean on the ends of the scale now and then.
	function automatic logic [15:0] random_word();
		case ($urandom_range(0, 9))
			0: return 16'h0000;
			1: return 16'hFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	// Offer one byte, optionally after a gap, and hold it until the block takes it.
	task automatic push_byte(input logic [7:0] b, input logic s);
		int unsigned gap;
		gap = idle_len();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= '{rx_byte: b, frame_start: s};
		do @(posedge clk); while (in_stall);
		bytes_sent++;
	endtask

	// Lay out a frame: per word high byte, low byte, CRC; one CRC may be spoiled.
	task automatic build_frame(input logic [15:0] w0, input logic [15:0] w1,
		input int words, input int bad_word);
		logic [15:0] w;
		logic [7:0]  c;
		frame_bytes.delete();
		for (int i = 0; i < words; i++) begin
			w = (i == 0) ? w0 : w1;
			c = crc8_byte(crc8_byte(CRC_INIT, w[15:8]), w[7:0]);
			if (i == bad_word) begin
				c = c ^ 8'($urandom_range(1, 255));
			end
			frame_bytes.push_back(w[15:8]);
			frame_bytes.push_back(w[7:0]);
			frame_bytes.push_back(c);
		end
	endtask

	// Send frame_bytes[lo..hi-1]; the start mark goes on the first one sent.
	task automatic push_range(input int lo, input int hi, input logic s);
		for (int i = lo; i < hi; i++) begin
			push_byte(frame_bytes[i], s && (i == lo));
		end
	endtask

	// Drop valid, wait for every reading to come back, then let the pipeline empty.
	task automatic settle();
		in_valid <= 1'b0;
		do @(posedge clk); while (readings_pending != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Setup cycle, then access cycle; the write lands on the edge with pready high.
	task automatic set_kind(input logic k);
		settle();
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= FRAME_KIND_ADDR;
		pwdata  <= {31'd0, k};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		kind_now = k;
	endtask

	// Mostly clean frames with random words; the rest spoiled CRCs,
	// cut-off frames and loose noise bytes with random start marks.
	task automatic random_frame();
		int unsigned r;
		int          words;
		logic        s;
		words = (kind_now == KIND_STATUS) ? 1 : 2;
		r = $urandom_range(0, 99);
		if (r < 82) begin
			build_frame(random_word(), random_word(), words,
				(r < 70) ? NO_BAD_WORD : int'($urandom_range(0, words - 1)));
			s = aligned ? 1'($urandom_range(0, 1)) : 1'b1;
			push_range(0, 3 * words, s);
			aligned = 1'b1;
		end else if (r < 92) begin
			build_frame(random_word(), random_word(), words, NO_BAD_WORD);
			push_range(0, $urandom_range(1, 3 * words - 1), 1'b1);
			aligned = 1'b0;
		end else begin
			repeat ($urandom_range(1, 4)) push_byte(8'($urandom), 1'($urandom_range(0, 1)));
			aligned = 1'b0;
		end
	endtask

	// Receiver: random stall runs, or one long hold-off when asked, counted here.
	initial begin : receiver
		int unsigned n;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_stall <= 1'b1;
				repeat (LONG_HOLD) @(posedge clk);
				out_stall <= 1'b0;
				hold_req = 1'b0;
			end else begin
				n = idle_len();
				if (n != 0) begin
					out_stall <= 1'b1;
					repeat (n) @(posedge clk);
					out_stall <= 1'b0;
				end
			end
		end
	end

	initial begin : stimulus
		int unsigned phase;
		int unsigned directed_bytes;
		int unsigned cut;
		int          words;
		int          drain_cycles;
		logic        new_kind;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		aligned = 1'b1;

		// Full-scale reading, then zero-scale sent without a start mark.
		build_frame(16'hFFFF, 16'hFFFF, 2, NO_BAD_WORD);
		push_range(0, 6, 1'b1);
		build_frame(16'h0000, 16'h0000, 2, NO_BAD_WORD);
		push_range(0, 6, 1'b0);

		// Restart two bytes into a frame; the new one has a bad temperature CRC,
		// so the held values must stay put.
		build_frame(16'h1234, 16'h5678, 2, NO_BAD_WORD);
		push_range(0, 2, 1'b1);
		build_frame(16'h8000, 16'h7FFF, 2, 0);
		push_range(0, 6, 1'b1);

		// Switch to status frames two bytes in: the CRC byte closes a status frame.
		build_frame(16'hA55A, 16'h0000, 1, NO_BAD_WORD);
		push_range(0, 2, 1'b1);
		set_kind(KIND_STATUS);
		push_range(2, 3, 1'b0);

		// Status frame with a broken CRC.
		build_frame(16'hFFFF, 16'h0000, 1, 0);
		push_range(0, 3, 1'b1);
		aligned = 1'b1;
		directed_bytes = bytes_sent;

		// Random phases. Phase 0 runs status frames under a long receiver hold-off
		// so the block backs up; phase 1 returns to measurement; calm every fourth.
		phase = 0;
		while (bytes_sent < directed_bytes + RANDOM_BYTES) begin
			if (phase == 0) begin
				new_kind = KIND_STATUS;
			end else if (phase == 1) begin
				new_kind = KIND_MEASURE;
			end else begin
				new_kind = 1'($urandom_range(0, 1));
			end
			calm = (phase % 4 == 3);

			// Sometimes change the kind partway through a frame, after the block drains.
			if (phase != 0 && $urandom_range(0, 2) == 0) begin
				words = (kind_now == KIND_STATUS) ? 1 : 2;
				build_frame(random_word(), random_word(), words, NO_BAD_WORD);
				cut = $urandom_range(1, 3 * words - 1);
				push_range(0, cut, 1'b1);
				set_kind(new_kind);
				push_range(cut, 3 * words, 1'b0);
				aligned = 1'b0;
			end else begin
				set_kind(new_kind);
			end

			if (phase == 0 || $urandom_range(0, 5) == 0) begin
				hold_req = 1'b1;
			end
			repeat ($urandom_range(6, 16)) random_frame();
			phase++;
		end

		// Wait for the last readings, bounded, then wait out SETTLE_CYCLES for strays.
		in_valid <= 1'b0;
		drain_cycles = 0;
		do begin
			@(posedge clk);
			drain_cycles++;
		end while (readings_pending != 0 && drain_cycles < DRAIN_LIMIT);
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (mismatch_count == 0 && readings_pending == 0) begin
			$display("humidity_sensor_frame_decoder_unit verification clean");
		end else begin
			$display("humidity_sensor_frame_decoder_unit verification failed");
		end
		$finish;
	end

	// Hard stop well beyond the slowest legal run.
	initial begin : watchdog
		#(12 * 1000000);
		$display("humidity_sensor_frame_decoder_unit verification failed");
		$finish;
	end

endmodule
